/* sv/ns_pkg.sv */
`default_nettype none

package ns_pkg;

    // Framing limits
    localparam int MAX_DIGITS = 9;
    localparam int LEN_W      = 30;
    localparam int CNT_W      = 4;

    // Depth of the queue between classifier and sequencer
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    // Characters of interest
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    // Result
    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             payload_last;
        logic             frame_done;
        logic [LEN_W-1:0] frame_length;
        logic             error_flag;
        logic [2:0]       error_code;
    } t_out_item;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       eob;
        logic       is_digit;
        logic       is_zero;
        logic       is_colon;
        logic       is_comma;
        logic [3:0] digit;
    } t_class;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_DIGITS,
        PH_BODY,
        PH_COMMA,
        PH_DRAIN
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NO_LENGTH,
        ERR_LEADING_ZERO,
        ERR_TOO_LONG,
        ERR_NO_COLON,
        ERR_NO_COMMA,
        ERR_TOO_SHORT
    } t_err;

endpackage

`default_nettype wire

/* sv/ns_front.sv */
`default_nettype none

module ns_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  ns_pkg::t_in_item     i_item,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output ns_pkg::t_class       o_cls
);
    import ns_pkg::*;

    logic   r_valid;
    t_class r_cls;
    t_class n_cls;

    // Hold while a classified byte waits downstream
    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    // Byte classification
    always_comb begin
        n_cls.data     = i_item.data_byte;
        n_cls.eob      = i_item.end_of_buffer;
        n_cls.is_digit = (i_item.data_byte >= CH_ZERO) && (i_item.data_byte <= CH_NINE);
        n_cls.is_zero  = (i_item.data_byte == CH_ZERO);
        n_cls.is_colon = (i_item.data_byte == CH_COLON);
        n_cls.is_comma = (i_item.data_byte == CH_COMMA);
        n_cls.digit    = 4'(i_item.data_byte - CH_ZERO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

/* sv/ns_queue.sv */
`default_nettype none

module ns_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  ns_pkg::t_class       i_cls,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output ns_pkg::t_class       o_cls
);
    import ns_pkg::*;

    t_class            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_stall = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd_ptr];

    assign wr_en = i_valid & ~o_stall;
    assign rd_en = o_valid & ~i_stall;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

`default_nettype wire

/* sv/ns_back.sv */
`default_nettype none

module ns_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  ns_pkg::t_class       i_cls,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output ns_pkg::t_out_item    o_item
);
    import ns_pkg::*;

    t_phase            r_phase,  n_phase;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [LEN_W-1:0]  r_left,   n_left;
    logic              r_fdz,    n_fdz;
    logic              r_valid;
    t_out_item         r_out,    n_out;

    logic              take;
    logic [LEN_W+2:0]  len_x10;
    t_err              err;

    assign o_stall = r_valid & i_stall;
    assign take    = i_valid & ~o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_out;

    // len * 10 + digit as two shifted adds
    assign len_x10 = {r_len, 3'b000} + {2'b00, r_len, 1'b0} + (LEN_W+3)'(i_cls.digit);

    // Frame sequencer: next state and result
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_len   = r_len;
        n_left  = r_left;
        n_fdz   = r_fdz;
        err     = ERR_NONE;
        n_out   = '0;

        case (r_phase)
            PH_FIRST: begin
                if (i_cls.is_digit) begin
                    n_fdz   = i_cls.is_zero;
                    n_len   = LEN_W'(i_cls.digit);
                    n_count = CNT_W'(1);
                    n_phase = PH_DIGITS;
                end else begin
                    err = ERR_NO_LENGTH;
                end
            end
            PH_DIGITS: begin
                if (i_cls.is_digit) begin
                    if (r_fdz) begin
                        err = ERR_LEADING_ZERO;
                    end else if (r_count >= CNT_W'(MAX_DIGITS)) begin
                        err = ERR_TOO_LONG;
                    end else begin
                        n_len   = len_x10[LEN_W-1:0];
                        n_count = r_count + 1'b1;
                    end
                end else if (i_cls.is_colon) begin
                    n_left  = r_len;
                    n_phase = (r_len == '0) ? PH_COMMA : PH_BODY;
                end else begin
                    err = ERR_NO_COLON;
                end
            end
            PH_BODY: begin
                n_out.payload_valid = 1'b1;
                n_out.payload_byte  = i_cls.data;
                n_out.payload_last  = (r_left <= LEN_W'(1));
                n_left = (r_left == '0) ? '0 : r_left - 1'b1;
                if (n_left == '0) begin
                    n_phase = PH_COMMA;
                end
            end
            PH_COMMA: begin
                if (i_cls.is_comma) begin
                    n_out.frame_done   = 1'b1;
                    n_out.frame_length = r_len;
                    n_phase = PH_FIRST;
                    n_count = '0;
                    n_len   = '0;
                    n_left  = '0;
                    n_fdz   = 1'b0;
                end else begin
                    err = ERR_NO_COMMA;
                end
            end
            default: begin
                // draining after a fault: nothing to report
            end
        endcase

        if (err != ERR_NONE) begin
            n_phase = PH_DRAIN;
        end

        // End of buffer: mid-frame cut reports too_short, then restart
        if (i_cls.eob) begin
            if ((r_phase != PH_DRAIN) && (err == ERR_NONE) && !n_out.frame_done) begin
                err = ERR_TOO_SHORT;
            end
            n_phase = PH_FIRST;
            n_count = '0;
            n_len   = '0;
            n_left  = '0;
            n_fdz   = 1'b0;
        end

        n_out.error_flag = (err != ERR_NONE);
        n_out.error_code = err;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_count <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_fdz   <= 1'b0;
        end else if (take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_left  <= n_left;
            r_fdz   <= n_fdz;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* sv/netstring_deframer.sv */
// Netstring deframer: splits a byte stream of "digits:payload," frames.
//
// Input channel: one byte per request (data_byte, end_of_buffer) on
// i_valid / o_stall. Output channel: one result per input byte on
// o_valid / i_stall, carrying a body byte with its last mark, a frame
// completion with the declared length, or a fault code. Bytes that are
// dropped after a fault still give a result with every field zero.
//
// A result reaches o_item through the classifier register, which loads
// at the accepting edge, then the two-entry queue and the output
// register of the frame sequencer.
// Throughput is one byte per cycle while the receiver does not stall, set
// by the sequencer, which updates the length, count and phase once per byte.
//
// Reset (synchronous, active low) empties the queue and the pipeline
// and leaves the sequencer awaiting the first length digit.
// When the receiver stalls, the result holds; the queue fills, then the
// classifier holds, and o_stall rises once the queue is full while the
// classifier register still holds a byte.
`default_nettype none

module netstring_deframer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  ns_pkg::t_in_item     i_item,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output ns_pkg::t_out_item    o_item
);
    import ns_pkg::*;

    logic   f_valid, f_stall;
    t_class f_cls;
    logic   q_valid, q_stall;
    t_class q_cls;

    // Classifier
    ns_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (f_valid),
        .i_stall (f_stall),
        .o_cls   (f_cls)
    );

    // Decoupling queue
    ns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_cls   (f_cls),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_cls   (q_cls)
    );

    // Frame sequencer
    ns_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_stall (q_stall),
        .i_cls   (q_cls),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // A frame end never shares a result with a body byte or a fault
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_item.frame_done && (o_item.payload_valid || o_item.error_flag)))
        else $error("frame end mixed with body byte or fault");

    // Fault flag agrees with its code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.error_flag == (o_item.error_code != ERR_NONE)))
        else $error("error flag and error code disagree");

    // Last mark only on a body byte
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.payload_last) |-> o_item.payload_valid)
        else $error("payload_last without payload byte");

    // Queue absorbs a stalled output before the input side is held
    a_stall_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !$past(o_stall)) |-> $past(o_valid && i_stall))
        else $error("input stalled without a blocked output");

endmodule

`default_nettype wire

/* sim/tb_netstring_deframer.sv */
module tb_netstring_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import ns_pkg::*;

    // Byte request waiting to be driven; hold_until_empty makes the sender
    // pause until every expected result has come back
    typedef struct packed {
        t_in_item item;
        logic     hold_until_empty;
    } t_byte_req;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    netstring_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_byte_req byte_reqs[$];
    t_out_item want_results[$];
    logic [7:0] frame_buf[$];

    int  sent_cnt     = 0;
    int  results_cnt  = 0;
    int  fail_cnt     = 0;
    int  calm_from    = 0;
    int  gap_left     = 0;
    int  hold_left    = 0;
    bit  long_hold_done = 1'b0;
    bit  pause_next   = 1'b0;
    bit  pause_placed = 1'b0;

    // Deframer state as the predictor tracks it
    t_phase           rx_phase;
    logic [3:0]       rx_digits;
    logic [LEN_W-1:0] rx_length;
    logic [LEN_W-1:0] rx_remaining;
    logic             rx_lead_zero;

    function automatic void restart_frame();
        rx_phase     = PH_FIRST;
        rx_digits    = '0;
        rx_length    = '0;
        rx_remaining = '0;
        rx_lead_zero = 1'b0;
    endfunction

    // Advance the deframer by one byte and return the result it gives
    function automatic t_out_item deframe_byte(t_in_item it);
        t_out_item r;
        t_err      err;
        logic      is_dig;
        logic      was_draining;
        r            = '0;
        err          = ERR_NONE;
        is_dig       = (it.data_byte >= CH_ZERO) && (it.data_byte <= CH_NINE);
        was_draining = (rx_phase == PH_DRAIN);
        case (rx_phase)
            PH_FIRST: begin
                if (is_dig) begin
                    rx_lead_zero = (it.data_byte == CH_ZERO);
                    rx_length    = LEN_W'(it.data_byte - CH_ZERO);
                    rx_digits    = 4'd1;
                    rx_phase     = PH_DIGITS;
                end else begin
                    err = ERR_NO_LENGTH;
                end
            end
            PH_DIGITS: begin
                if (is_dig) begin
                    if (rx_lead_zero)
                        err = ERR_LEADING_ZERO;
                    else if (rx_digits >= MAX_DIGITS)
                        err = ERR_TOO_LONG;
                    else begin
                        rx_length = LEN_W'(rx_length * 10 + (it.data_byte - CH_ZERO));
                        rx_digits = rx_digits + 4'd1;
                    end
                end else if (it.data_byte == CH_COLON) begin
                    rx_remaining = rx_length;
                    rx_phase     = (rx_length == '0) ? PH_COMMA : PH_BODY;
                end else begin
                    err = ERR_NO_COLON;
                end
            end
            PH_BODY: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = it.data_byte;
                r.payload_last  = (rx_remaining <= 1);
                if (rx_remaining != '0)
                    rx_remaining = rx_remaining - 1'b1;
                if (rx_remaining == '0)
                    rx_phase = PH_COMMA;
            end
            PH_COMMA: begin
                if (it.data_byte == CH_COMMA) begin
                    r.frame_done   = 1'b1;
                    r.frame_length = rx_length;
                    restart_frame();
                end else begin
                    err = ERR_NO_COMMA;
                end
            end
            default: ;
        endcase

        if (err != ERR_NONE)
            rx_phase = PH_DRAIN;

        // End of buffer: truncation unless the byte faulted or closed a frame
        if (it.end_of_buffer) begin
            if (!was_draining && err == ERR_NONE && !r.frame_done)
                err = ERR_TOO_SHORT;
            restart_frame();
        end

        r.error_flag = (err != ERR_NONE);
        r.error_code = err;
        return r;
    endfunction

    function automatic string fmt_result(t_out_item r);
        return $sformatf("pv=%0b pb=%02h pl=%0b fd=%0b len=%0d err=%0b code=%0d",
                         r.payload_valid, r.payload_byte, r.payload_last,
                         r.frame_done, r.frame_length, r.error_flag, r.error_code);
    endfunction

    // ---------------- stimulus building ----------------

    task automatic queue_byte(logic [7:0] b, logic eob);
        t_byte_req req;
        req.item.data_byte     = b;
        req.item.end_of_buffer = eob;
        req.hold_until_empty   = pause_next;
        pause_next             = 1'b0;
        byte_reqs.push_back(req);
    endtask

    // Fill frame_buf with a well-formed frame of the given body length
    task automatic load_frame(int unsigned len);
        string s;
        s = $sformatf("%0d", len);
        frame_buf.delete();
        for (int i = 0; i < s.len(); i++)
            frame_buf.push_back(s[i]);
        frame_buf.push_back(CH_COLON);
        for (int unsigned i = 0; i < len; i++)
            frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(CH_COMMA);
    endtask

    // Push the first n bytes of frame_buf; the last one carries eob if asked
    task automatic send_frame_buf(int n, logic eob_last);
        for (int i = 0; i < n; i++)
            queue_byte(frame_buf[i], eob_last && (i == n - 1));
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        else if (r < 96)
            return $urandom_range(7, 40);
        return $urandom_range(100, 250);
    endfunction

    function automatic logic [7:0] rand_byte_except(bit no_digit, logic [7:0] excl);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((no_digit && b >= CH_ZERO && b <= CH_NINE) || b == excl);
        return b;
    endfunction

    // Fault byte, then junk until a byte with the end mark
    task automatic fault_then_drain(logic [7:0] b);
        int n;
        if ($urandom_range(0, 2) == 0) begin
            queue_byte(b, 1'b1);
        end else begin
            queue_byte(b, 1'b0);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // One buffer: mostly good frames back to back, sometimes a broken one
    task automatic add_buffer();
        int  n_frames;
        int  n;
        bit  last;
        n_frames = $urandom_range(1, 4);
        for (int f = 0; f < n_frames; f++) begin
            last = (f == n_frames - 1);
            if ($urandom_range(0, 9) < 8) begin
                load_frame(pick_len());
                send_frame_buf(frame_buf.size(), last);
            end else begin
                case ($urandom_range(0, 6))
                    0: begin
                        // truncated frame
                        load_frame(pick_len());
                        send_frame_buf($urandom_range(1, frame_buf.size() - 1), 1'b1);
                    end
                    1: fault_then_drain(rand_byte_except(1'b1, CH_ZERO));
                    2: begin
                        queue_byte(CH_ZERO, 1'b0);
                        fault_then_drain(8'(CH_ZERO + $urandom_range(0, 9)));
                    end
                    3: begin
                        queue_byte(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
                        for (int i = 0; i < MAX_DIGITS - 1; i++)
                            queue_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                        fault_then_drain(8'(CH_ZERO + $urandom_range(0, 9)));
                    end
                    4: begin
                        n = $urandom_range(1, MAX_DIGITS);
                        queue_byte(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
                        for (int i = 1; i < n; i++)
                            queue_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                        fault_then_drain(rand_byte_except(1'b1, CH_COLON));
                    end
                    5: begin
                        load_frame(pick_len());
                        send_frame_buf(frame_buf.size() - 1, 1'b0);
                        fault_then_drain(rand_byte_except(1'b0, CH_COMMA));
                    end
                    default: begin
                        // plain noise ending in an end mark
                        n = $urandom_range(1, 6);
                        for (int i = 0; i < n; i++)
                            queue_byte(8'($urandom_range(0, 255)), i == n - 1);
                    end
                endcase
                break;
            end
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin : drive_proc
        t_byte_req req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                want_results.push_back(deframe_byte(i_item));
                sent_cnt++;
            end
            // A stalled request holds; otherwise pick the next one or idle
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (byte_reqs.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (byte_reqs[0].hold_until_empty && want_results.size() != 0) begin
                    i_valid <= 1'b0;
                end else if (sent_cnt < calm_from && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 8);
                    i_valid <= 1'b0;
                end else begin
                    req = byte_reqs.pop_front();
                    i_item  <= req.item;
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // ---------------- receiver back-pressure ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!long_hold_done && results_cnt >= 250) begin
            // long hold-off so the block fills and stalls its input
            long_hold_done = 1'b1;
            hold_left      = 79;
            i_stall <= 1'b1;
        end else if (results_cnt < calm_from && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 8);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin : check_proc
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_cnt++;
            if (want_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result %0d: %s", results_cnt, fmt_result(o_item));
            end else begin
                want = want_results.pop_front();
                if (want.payload_valid !== o_item.payload_valid ||
                    want.payload_byte  !== o_item.payload_byte  ||
                    want.payload_last  !== o_item.payload_last  ||
                    want.frame_done    !== o_item.frame_done    ||
                    want.frame_length  !== o_item.frame_length  ||
                    want.error_flag    !== o_item.error_flag    ||
                    want.error_code    !== o_item.error_code) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch on result %0d: expected %s, got %s",
                                 results_cnt, fmt_result(want), fmt_result(o_item));
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        restart_frame();

        // Directed: empty frame, then a short frame with extreme body bytes
        load_frame(0);
        send_frame_buf(frame_buf.size(), 1'b0);
        queue_byte(8'h32, 1'b0);
        queue_byte(CH_COLON, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(CH_COMMA, 1'b1);
        // missing length, then dropped until the end mark
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h31, 1'b1);
        // leading zero, fault and end mark on the same byte
        queue_byte(CH_ZERO, 1'b0);
        queue_byte(8'h31, 1'b1);
        // nine digits accepted, the tenth is one too many
        for (int i = 0; i < MAX_DIGITS; i++)
            queue_byte(CH_NINE, 1'b0);
        queue_byte(CH_NINE, 1'b1);
        // body byte with the end mark: passed through and reported short
        queue_byte(8'h31, 1'b0);
        queue_byte(CH_COLON, 1'b0);
        queue_byte(8'h61, 1'b1);
        // missing colon
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h78, 1'b1);
        // missing comma after an empty body
        queue_byte(CH_ZERO, 1'b0);
        queue_byte(CH_COLON, 1'b0);
        queue_byte(8'h61, 1'b1);

        // Random buffers; one request midway waits for the results to drain
        while (byte_reqs.size() < 820) begin
            if (byte_reqs.size() >= 450 && !pause_placed) begin
                pause_next   = 1'b1;
                pause_placed = 1'b1;
            end
            add_buffer();
        end
        calm_from = byte_reqs.size() - 100;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_reqs.size() != 0 || i_valid)
            @(posedge i_clk);
        while (want_results.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (fail_cnt == 0 && want_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
